>>> src/image_sharpen_five_point_defines.svh
// assertion helpers used by the isfp_checker module
`ifndef IMAGE_SHARPEN_FIVE_POINT_DEFINES_SVH
`define IMAGE_SHARPEN_FIVE_POINT_DEFINES_SVH

// checked on every clock edge outside reset
`define ISFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define ISFP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> src/isfp_pkg.sv
package isfp_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned CFG_DATA_W  = 13;
   localparam int unsigned DIM_CFG_W   = 13;
   localparam int unsigned CHAN_CFG_W  = 3;
   localparam int unsigned HEIGHT_W    = 13;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam int unsigned MIN_DIM     = 3;
   localparam int unsigned MIN_CHAN    = 1;
   localparam int unsigned MAX_HEIGHT  = 4096;

   localparam int unsigned MAX_WIDTH_DEFAULT    = 4096;
   localparam int unsigned MAX_CHANNELS_DEFAULT = 4;

   localparam logic [DIM_CFG_W-1:0]  RESET_IMAGE_WIDTH   = 13'd640;
   localparam logic [DIM_CFG_W-1:0]  RESET_IMAGE_HEIGHT  = 13'd480;
   localparam logic [CHAN_CFG_W-1:0] RESET_CHANNEL_COUNT = 3'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2
   } isfp_csr_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_FLUSH  = 1'b1
   } isfp_op_type;

   // decisions taken for one word when it is accepted
   typedef struct packed {
      logic is_sample;
      logic emit;
      logic interior;
      logic first;
      logic last;
   } isfp_item_type;

endpackage

>>> src/isfp_linebuf.sv
module isfp_linebuf #(
   parameter int unsigned DEPTH  = 16384,
   parameter int unsigned WORD_W = 16,
   localparam int unsigned AddrW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AddrW-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AddrW-1:0]  wr_addr,
   input  logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] line_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/isfp_ctrl.sv
module isfp_ctrl #(
   parameter int unsigned MAX_WIDTH    = isfp_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_CHANNELS = isfp_pkg::MAX_CHANNELS_DEFAULT,
   localparam int unsigned LineDepth = MAX_WIDTH * MAX_CHANNELS,
   localparam int unsigned AddrW     = $clog2(LineDepth),
   localparam int unsigned ColW      = $clog2(LineDepth + 1),
   localparam int unsigned ChanW     = $clog2(MAX_CHANNELS + 1),
   localparam int unsigned WidW      = $clog2(MAX_WIDTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [isfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [isfp_pkg::CFG_DATA_W-1:0]      csr_wdata,
   input  logic                                 accept,
   input  logic                                 advance,
   input  logic                                 item_op,
   input  logic [isfp_pkg::DATA_W-1:0]          item_sample,
   output logic [ChanW-1:0]                     chan_count,
   output logic                                 rd_en,
   output logic [AddrW-1:0]                     rd_addr,
   output logic                                 stage_valid,
   output isfp_pkg::isfp_item_type              stage_item,
   output logic [isfp_pkg::DATA_W-1:0]          stage_sample,
   output logic [AddrW-1:0]                     stage_addr
);
   import isfp_pkg::*;

   logic [DIM_CFG_W-1:0]  width_cfg_ff;
   logic [DIM_CFG_W-1:0]  height_cfg_ff;
   logic [CHAN_CFG_W-1:0] chan_cfg_ff;

   logic [WidW-1:0]     w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [ChanW-1:0]    c_eff;
   logic [ColW-1:0]     row_len;
   logic [ColW:0]       lag;

   logic [ColW-1:0]     in_col_ff, in_col_in;
   logic [HEIGHT_W-1:0] in_row_ff, in_row_in;
   logic [ColW-1:0]     out_col_ff, out_col_in;
   logic [HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [ColW:0]       pending_ff, pending_in;

   logic                stage_valid_ff;
   isfp_item_type       stage_item_ff;
   isfp_item_type       item;
   logic [DATA_W-1:0]   stage_sample_ff;
   logic [AddrW-1:0]    stage_addr_ff;

   logic cfg_hit;
   logic is_sample;
   logic in_col_wrap;
   logic out_col_wrap;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= RESET_IMAGE_WIDTH;
         height_cfg_ff <= RESET_IMAGE_HEIGHT;
         chan_cfg_ff   <= RESET_CHANNEL_COUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_cfg_ff  <= csr_wdata[DIM_CFG_W-1:0];
            CSR_IMAGE_HEIGHT:  height_cfg_ff <= csr_wdata[DIM_CFG_W-1:0];
            CSR_CHANNEL_COUNT: chan_cfg_ff   <= csr_wdata[CHAN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg_hit = csr_we && (csr_index == CSR_IMAGE_WIDTH ||
                               csr_index == CSR_IMAGE_HEIGHT ||
                               csr_index == CSR_CHANNEL_COUNT);

   // registers clamped to the supported range
   always_comb begin
      if (32'(width_cfg_ff) < MIN_DIM) begin
         w_eff = WidW'(MIN_DIM);
      end else if (32'(width_cfg_ff) > MAX_WIDTH) begin
         w_eff = WidW'(MAX_WIDTH);
      end else begin
         w_eff = WidW'(width_cfg_ff);
      end
      if (32'(height_cfg_ff) < MIN_DIM) begin
         h_eff = HEIGHT_W'(MIN_DIM);
      end else if (32'(height_cfg_ff) > MAX_HEIGHT) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = HEIGHT_W'(height_cfg_ff);
      end
      if (32'(chan_cfg_ff) < MIN_CHAN) begin
         c_eff = ChanW'(MIN_CHAN);
      end else if (32'(chan_cfg_ff) > MAX_CHANNELS) begin
         c_eff = ChanW'(MAX_CHANNELS);
      end else begin
         c_eff = ChanW'(chan_cfg_ff);
      end
   end

   // words per row, and the distance from an input word to the result it completes
   assign row_len = ColW'(w_eff) * ColW'(c_eff);
   assign lag     = {1'b0, row_len} + (ColW + 1)'(c_eff);

   assign is_sample    = (item_op == OP_SAMPLE);
   assign in_col_wrap  = (in_col_ff + ColW'(1)) == row_len;
   assign out_col_wrap = (out_col_ff + ColW'(1)) == row_len;

   always_comb begin
      item.is_sample = is_sample;
      if (is_sample) begin
         item.emit = pending_ff >= lag;
      end else begin
         item.emit = (pending_ff != '0) && (in_row_ff == '0) && (in_col_ff == '0);
      end
      item.interior = is_sample && (out_row_ff != '0) &&
                      ((out_row_ff + HEIGHT_W'(2)) <= h_eff) &&
                      (out_col_ff >= ColW'(c_eff)) &&
                      (({1'b0, out_col_ff} + (ColW + 1)'(c_eff)) < {1'b0, row_len});
      item.first = (out_row_ff == '0) && (out_col_ff == '0);
      item.last  = (out_row_ff == (h_eff - HEIGHT_W'(1))) && out_col_wrap;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;
      if (cfg_hit) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pending_in = '0;
      end else if (accept) begin
         if (is_sample) begin
            if (in_col_wrap) begin
               in_col_in = '0;
               in_row_in = ((in_row_ff + HEIGHT_W'(1)) == h_eff) ? '0
                                                                 : in_row_ff + HEIGHT_W'(1);
            end else begin
               in_col_in = in_col_ff + ColW'(1);
            end
            if (!item.emit) begin
               pending_in = pending_ff + (ColW + 1)'(1);
            end
         end else if (item.emit) begin
            pending_in = pending_ff - (ColW + 1)'(1);
         end
         if (item.emit) begin
            if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = ((out_row_ff + HEIGHT_W'(1)) == h_eff) ? '0
                                                                   : out_row_ff + HEIGHT_W'(1);
            end else begin
               out_col_in = out_col_ff + ColW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff      <= '0;
         in_row_ff      <= '0;
         out_col_ff     <= '0;
         out_row_ff     <= '0;
         pending_ff     <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pending_ff <= pending_in;
         if (accept) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff   <= item;
         stage_sample_ff <= item_sample;
         stage_addr_ff   <= in_col_ff[AddrW-1:0];
      end
   end

   assign chan_count   = c_eff;
   assign rd_en        = accept && is_sample;
   assign rd_addr      = in_col_ff[AddrW-1:0];
   assign stage_valid  = stage_valid_ff;
   assign stage_item   = stage_item_ff;
   assign stage_sample = stage_sample_ff;
   assign stage_addr   = stage_addr_ff;

endmodule

>>> src/isfp_datapath.sv
module isfp_datapath #(
   parameter int unsigned MAX_CHANNELS = isfp_pkg::MAX_CHANNELS_DEFAULT,
   localparam int unsigned ChanW     = $clog2(MAX_CHANNELS + 1),
   localparam int unsigned HistDepth = 2 * MAX_CHANNELS + 1,
   localparam int unsigned HistIdxW  = $clog2(HistDepth)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              stage_valid,
   input  isfp_pkg::isfp_item_type           stage_item,
   input  logic [isfp_pkg::DATA_W-1:0]       stage_sample,
   input  logic [2*isfp_pkg::DATA_W-1:0]     line_word,
   input  logic [ChanW-1:0]                  chan_count,
   output logic                              out_valid,
   output logic [isfp_pkg::DATA_W-1:0]       out_value,
   output logic                              out_first,
   output logic                              out_last
);
   import isfp_pkg::*;

   localparam int unsigned AccW = DATA_W + 4;

   // word history of the middle row, the upper row and the incoming row
   logic [DATA_W-1:0] mid_hist_ff [HistDepth];
   logic [DATA_W-1:0] up_hist_ff  [HistDepth];
   logic [DATA_W-1:0] dn_hist_ff  [HistDepth];
   logic [DATA_W-1:0] mid_now     [HistDepth];
   logic [DATA_W-1:0] up_now      [HistDepth];
   logic [DATA_W-1:0] dn_now      [HistDepth];

   logic                 push;
   logic [HistIdxW-1:0]  idx_c;
   logic [HistIdxW-1:0]  idx_2c;
   logic [DATA_W-1:0]    center;
   logic [DATA_W+2:0]    center5;
   logic signed [AccW-1:0] acc;
   logic [DATA_W-1:0]    sharp;

   logic              out_valid_ff;
   logic [DATA_W-1:0] out_value_ff;
   logic              out_first_ff;
   logic              out_last_ff;

   assign push = advance && stage_valid && stage_item.is_sample;

   // history as it stands once this word is shifted in
   always_comb begin
      mid_now[0] = line_word[DATA_W +: DATA_W];
      up_now[0]  = line_word[0 +: DATA_W];
      dn_now[0]  = stage_sample;
      for (int k = 1; k < HistDepth; k++) begin
         mid_now[k] = mid_hist_ff[k-1];
         up_now[k]  = up_hist_ff[k-1];
         dn_now[k]  = dn_hist_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int k = 0; k < HistDepth; k++) begin
            mid_hist_ff[k] <= mid_now[k];
            up_hist_ff[k]  <= up_now[k];
            dn_hist_ff[k]  <= dn_now[k];
         end
      end
   end

   assign idx_c   = HistIdxW'(chan_count);
   assign idx_2c  = HistIdxW'({chan_count, 1'b0});
   assign center  = mid_now[idx_c];
   assign center5 = {1'b0, center, 2'b00} + (DATA_W + 3)'(center);

   always_comb begin
      acc = $signed(AccW'(center5))
          - $signed(AccW'(mid_now[0]))
          - $signed(AccW'(mid_now[idx_2c]))
          - $signed(AccW'(up_now[idx_c]))
          - $signed(AccW'(dn_now[idx_c]));
      priority if (acc[AccW-1]) begin
         sharp = '0;
      end else if (acc[AccW-2:DATA_W] != '0) begin
         sharp = '1;
      end else begin
         sharp = acc[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stage_valid && stage_item.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff <= stage_item.interior ? sharp : '0;
         out_first_ff <= stage_item.first;
         out_last_ff  <= stage_item.last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_first = out_first_ff;
   assign out_last  = out_last_ff;

endmodule

>>> src/image_sharpen_five_point.sv
// Five-point (cross Laplacian) sharpening of a raster stream of 8-bit,
// channel-interleaved samples. Each interior sample becomes
// 5*center - left - right - up - down of the same channel, clamped to 0..255;
// the first and last row and the first and last pixel column come out as zero.
// One word is taken per clock with no bubbles while the output is not stalled;
// the result that a word completes passes through the stage register and then
// the output register, and results trail the input by one row plus one pixel
// ((width + 1) * channels words). After the last sample of a frame, flush words
// (tuser = 1) each drain one pending result; a flush with nothing pending, or
// sent in the middle of a frame, yields nothing. The two previous rows sit in
// one MAX_WIDTH * MAX_CHANNELS x 16-bit memory, read once and written once per
// sample, which sets the one-word-per-clock rate. The memory is not cleared
// after reset: no interior result ever reads a location not written earlier in
// the same frame. Writing any register restarts the frame position and drops
// pending results; write registers only while the block is idle.
module image_sharpen_five_point #(
   parameter int unsigned MAX_WIDTH    = isfp_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_CHANNELS = isfp_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [isfp_pkg::DATA_W-1:0]      req_tdata,   // [7:0] sample
   input  logic [0:0]                       req_tuser,   // [0] opcode, 1 = flush
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [isfp_pkg::DATA_W-1:0]      rsp_tdata,   // [7:0] value
   output logic [0:0]                       rsp_tuser,   // [0] frame_start
   output logic                             rsp_tlast,   // frame_end
   input  logic                             csr_we,
   input  logic [isfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [isfp_pkg::CFG_DATA_W-1:0]  csr_wdata
);
   import isfp_pkg::*;

   localparam int unsigned LineDepth = MAX_WIDTH * MAX_CHANNELS;
   localparam int unsigned AddrW     = $clog2(LineDepth);
   localparam int unsigned ChanW     = $clog2(MAX_CHANNELS + 1);
   localparam int unsigned LineWordW = 2 * DATA_W;

   logic                 accept;
   logic                 advance;
   logic [ChanW-1:0]     chan_count;
   logic                 rd_en;
   logic [AddrW-1:0]     rd_addr;
   logic                 stage_valid;
   isfp_item_type        stage_item;
   logic [DATA_W-1:0]    stage_sample;
   logic [AddrW-1:0]     stage_addr;
   logic [LineWordW-1:0] line_word;
   logic                 wr_en;
   logic [LineWordW-1:0] wr_word;

   // the stage moves whenever the output register is empty or being emptied
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !stage_valid || advance;
   assign accept     = req_tvalid && req_tready;

   isfp_ctrl #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .advance      (advance),
      .item_op      (req_tuser[0]),
      .item_sample  (req_tdata),
      .chan_count   (chan_count),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .stage_valid  (stage_valid),
      .stage_item   (stage_item),
      .stage_sample (stage_sample),
      .stage_addr   (stage_addr)
   );

   // word layout: middle row above, upper row below; the middle row moves up
   assign wr_en   = advance && stage_valid && stage_item.is_sample;
   assign wr_word = {stage_sample, line_word[DATA_W +: DATA_W]};

   isfp_linebuf #(
      .DEPTH  (LineDepth),
      .WORD_W (LineWordW)
   ) u_linebuf (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (line_word),
      .wr_en   (wr_en),
      .wr_addr (stage_addr),
      .wr_data (wr_word)
   );

   isfp_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .stage_valid  (stage_valid),
      .stage_item   (stage_item),
      .stage_sample (stage_sample),
      .line_word    (line_word),
      .chan_count   (chan_count),
      .out_valid    (rsp_tvalid),
      .out_value    (rsp_tdata),
      .out_first    (rsp_tuser[0]),
      .out_last     (rsp_tlast)
   );

endmodule

>>> src/isfp_checker.sv
`include "image_sharpen_five_point_defines.svh"

module isfp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [isfp_pkg::DATA_W-1:0] rsp_tdata,
   input logic [0:0]                  rsp_tuser,
   input logic                        rsp_tlast
);
   import isfp_pkg::*;

   `ISFP_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_tvalid, "result valid after reset")

   // a free or draining output slot never blocks the input side
   `ISFP_ASSERT(a_ready_when_free, (!rsp_tvalid || rsp_tready) |-> req_tready, "input stalled with free output")

   `ISFP_ASSERT(a_hold_stalled, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)), "stalled result changed")

   // first and last word of a frame are border words
   `ISFP_ASSERT(a_border_zero, (rsp_tvalid && (rsp_tuser[0] || rsp_tlast)) |-> (rsp_tdata == '0), "frame edge word not zero")

   `ISFP_ASSERT(a_start_end_apart, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tlast), "frame start and end on one word")

endmodule

bind image_sharpen_five_point isfp_checker u_isfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/sharpen_checker.sv
module sharpen_checker #(
   parameter int unsigned MAX_WIDTH    = isfp_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_CHANNELS = isfp_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [isfp_pkg::DATA_W-1:0]      req_tdata,   // [7:0] sample
   input  logic [0:0]                       req_tuser,   // [0] opcode
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [isfp_pkg::DATA_W-1:0]      rsp_tdata,   // [7:0] value
   input  logic [0:0]                       rsp_tuser,   // [0] frame_start
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [isfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [isfp_pkg::CFG_DATA_W-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               awaited,
   output int                               results_checked,
   output int                               frames_closed
);
   timeunit 1ns;
   timeprecision 1ps;

   import isfp_pkg::*;

   localparam int unsigned LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int unsigned TAP_DEPTH  = 2 * MAX_CHANNELS + 1;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              frame_start;
      logic              frame_end;
   } sharpened_type;

   // rows minus two and minus one of the incoming image
   logic [DATA_W-1:0] above_row [LINE_DEPTH];
   logic [DATA_W-1:0] prior_row [LINE_DEPTH];
   // recent reads of those rows and of the incoming samples, newest at 0
   logic [DATA_W-1:0] prior_taps   [TAP_DEPTH];
   logic [DATA_W-1:0] above_taps   [TAP_DEPTH];
   logic [DATA_W-1:0] current_taps [TAP_DEPTH];

   logic [DIM_CFG_W-1:0]  width_reg;
   logic [DIM_CFG_W-1:0]  height_reg;
   logic [CHAN_CFG_W-1:0] chan_reg;
   int unsigned row_at, col_at, next_out, backlog;

   sharpened_type pending_pixels [$];
   sharpened_type want;

   function automatic int unsigned bounded(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic queue_result(input logic [DATA_W-1:0] v, input int unsigned frame_len);
      sharpened_type item;
      item.value       = v;
      item.frame_start = (next_out == 0);
      item.frame_end   = (next_out + 1 == frame_len);
      pending_pixels   = {pending_pixels, item};
      next_out = (next_out + 1 >= frame_len) ? 0 : next_out + 1;
   endtask

   task automatic sharpen_step(input isfp_op_type op, input logic [DATA_W-1:0] pixel);
      int unsigned chans, cols, rows, row_len, frame_len, lag, out_row, out_col, x;
      int acc;
      logic [DATA_W-1:0] v;
      chans     = bounded(32'(chan_reg), MIN_CHAN, MAX_CHANNELS);
      cols      = bounded(32'(width_reg), MIN_DIM, MAX_WIDTH);
      rows      = bounded(32'(height_reg), MIN_DIM, MAX_HEIGHT);
      row_len   = cols * chans;
      frame_len = row_len * rows;
      lag       = row_len + chans;

      if (op == OP_FLUSH) begin
         // drains only between frames
         if (backlog == 0 || row_at != 0 || col_at != 0) return;
         backlog--;
         queue_result('0, frame_len);
         return;
      end

      x = (col_at >= row_len) ? row_len - 1 : col_at;
      for (int i = TAP_DEPTH - 1; i > 0; i--) begin
         prior_taps[i]   = prior_taps[i-1];
         above_taps[i]   = above_taps[i-1];
         current_taps[i] = current_taps[i-1];
      end
      prior_taps[0]   = prior_row[x];
      above_taps[0]   = above_row[x];
      current_taps[0] = pixel;
      above_row[x]    = prior_row[x];
      prior_row[x]    = pixel;

      col_at = x + 1;
      if (col_at >= row_len) begin
         col_at = 0;
         row_at = (row_at + 1 >= rows) ? 0 : row_at + 1;
      end

      backlog++;
      if (backlog <= lag) return;
      backlog--;

      out_row = next_out / row_len;
      out_col = next_out % row_len;
      v = '0;
      if (out_row >= 1 && out_row + 2 <= rows && out_col >= chans && out_col + chans < row_len)
      begin
         acc = 5 * int'(prior_taps[chans]) - int'(prior_taps[2*chans]) - int'(prior_taps[0])
               - int'(above_taps[chans]) - int'(current_taps[chans]);
         if (acc < 0) v = '0;
         else if (acc > 255) v = 8'd255;
         else v = acc[DATA_W-1:0];
      end
      queue_result(v, frame_len);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_DEPTH; i++) begin
            above_row[i] = '0;
            prior_row[i] = '0;
         end
         for (int i = 0; i < TAP_DEPTH; i++) begin
            prior_taps[i]   = '0;
            above_taps[i]   = '0;
            current_taps[i] = '0;
         end
         width_reg  = RESET_IMAGE_WIDTH;
         height_reg = RESET_IMAGE_HEIGHT;
         chan_reg   = RESET_CHANNEL_COUNT;
         row_at = 0;
         col_at = 0;
         next_out = 0;
         backlog = 0;
         pending_pixels.delete();
         mismatches = 0;
         results_checked = 0;
         frames_closed = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               $error("result word with nothing expected: value %0d", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_pixels.pop_front();
               results_checked++;
               if (rsp_tdata !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser[0] !== want.frame_start) begin
                  $error("frame_start: expected %0b, actual %0b", want.frame_start, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tlast !== want.frame_end) begin
                  $error("frame_end: expected %0b, actual %0b", want.frame_end, rsp_tlast);
                  mismatches++;
               end
               if (want.frame_end) frames_closed++;
            end
         end

         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: width_reg = csr_wdata[DIM_CFG_W-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata[DIM_CFG_W-1:0];
               CSR_CHANNEL_COUNT: chan_reg = csr_wdata[CHAN_CFG_W-1:0];
               default: ;
            endcase
            // any real register write restarts the frame and drops the backlog
            if (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT ||
                csr_index == CSR_CHANNEL_COUNT) begin
               row_at = 0;
               col_at = 0;
               next_out = 0;
               backlog = 0;
            end
         end

         if (req_tvalid && req_tready) sharpen_step(isfp_op_type'(req_tuser[0]), req_tdata);
      end
      awaited = pending_pixels.size();
   end

endmodule

>>> tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import isfp_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_WORDS  = 1500;

   localparam int STYLE_RANDOM  = 0;
   localparam int STYLE_EXTREME = 1;
   localparam int STYLE_FLAT    = 2;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [DATA_W-1:0]      req_tdata  = '0;   // [7:0] sample
   logic [0:0]             req_tuser  = '0;   // [0] opcode, 1 = flush
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CFG_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [DATA_W-1:0]      rsp_tdata;         // [7:0] value
   logic [0:0]             rsp_tuser;         // [0] frame_start
   logic                   rsp_tlast;         // frame_end

   int mismatches, awaited, results_checked, frames_closed;

   int unsigned burst_left = 0;
   int unsigned eff_w = 640, eff_h = 480, eff_c = 3;
   int words_sent = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   image_sharpen_five_point dut (.*);

   sharpen_checker u_checker (.*);

   always #5ns clock = ~clock;

   // nothing accepted on any port for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver backpressure: free-running ready, random ready, or hard stalls
   initial begin
      int unsigned mode, span;
      forever begin
         mode = $urandom_range(2);
         span = $urandom_range(1, 60);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(99) < 60);
               default: rsp_tready <= 1'b0;
            endcase
            if (mode == 2 && span > 40) break;
         end
      end
   end

   function automatic int unsigned bounded(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // bursts of back-to-back words separated by random gaps
   task automatic pace();
      int unsigned gap;
      if (burst_left == 0) begin
         if ($urandom_range(4) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_word(input isfp_op_type op, input logic [DATA_W-1:0] s);
      pace();
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // hold the sender until every expected result is out and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (awaited != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] c);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_CHANNEL_COUNT;
      csr_wdata <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      eff_w = bounded(32'(w), MIN_DIM, MAX_WIDTH_DEFAULT);
      eff_h = bounded(32'(h), MIN_DIM, MAX_HEIGHT);
      eff_c = bounded(32'(c[CHAN_CFG_W-1:0]), MIN_CHAN, MAX_CHANNELS_DEFAULT);
      settings_used++;
   endtask

   // a write to the unused index must leave the frame position alone
   task automatic write_spare();
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_SPARE_INDEX;
      csr_wdata <= CFG_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain(input int unsigned n);
      repeat (n) send_word(OP_FLUSH, DATA_W'($urandom));
   endtask

   task automatic send_frame(input int unsigned count, input int style, input bit noisy);
      int unsigned base;
      logic [DATA_W-1:0] s;
      base = $urandom_range(0, 225);
      for (int unsigned i = 0; i < count; i++) begin
         case (style)
            STYLE_EXTREME: s = $urandom_range(1) ? 8'd255 : 8'd0;
            STYLE_FLAT: s = DATA_W'(base + $urandom_range(0, 30));
            default: s = DATA_W'($urandom);
         endcase
         if (noisy && $urandom_range(24) == 0) send_word(OP_FLUSH, DATA_W'($urandom));
         if ($urandom_range(399) == 0) begin
            if ($urandom_range(1)) write_spare();
            else settle();
         end
         send_word(OP_SAMPLE, s);
      end
   endtask

   initial begin
      int unsigned frame_len, lag, random_samples, partial;
      logic [CFG_DATA_W-1:0] w, h, c;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // smallest image: saturating high, then straight into a frame saturating low
      set_geometry(13'd3, 13'd3, 13'd1);
      send_word(OP_FLUSH, 8'hff);
      for (int i = 0; i < 9; i++) send_word(OP_SAMPLE, (i % 2 == 0) ? 8'd255 : 8'd0);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_word(OP_FLUSH, 8'h00);
         send_word(OP_SAMPLE, (i % 2 == 0) ? 8'd0 : 8'd255);
      end
      drain(5);

      // widest rows with four channels and the tallest image, each only partly sent
      set_geometry(13'd4096, 13'd3, 13'd7);
      send_frame($urandom_range(40, 80), STYLE_RANDOM, 1'b1);
      set_geometry(13'd1, 13'd8191, 13'd0);
      send_frame(eff_w * eff_c * 12, STYLE_FLAT, 1'b0);
      drain((eff_w + 1) * eff_c + 2);

      random_samples = 0;
      while (random_samples < RANDOM_WORDS) begin
         w = CFG_DATA_W'($urandom_range(3, 12));
         h = CFG_DATA_W'($urandom_range(3, 8));
         c = CFG_DATA_W'($urandom_range(1, 4));
         case ($urandom_range(9))
            0: w = CFG_DATA_W'($urandom_range(0, 2));
            1: h = CFG_DATA_W'($urandom_range(0, 2));
            2: c = CFG_DATA_W'($urandom_range(5, 8) & 7);
            3: h = CFG_DATA_W'(8191 - $urandom_range(0, 3));
            default: ;
         endcase
         // upper bits of the channel word are don't-care
         if ($urandom_range(1)) c = c | (CFG_DATA_W'($urandom) << CHAN_CFG_W);
         set_geometry(w, h, c);
         frame_len = eff_w * eff_c * eff_h;
         lag = (eff_w + 1) * eff_c;
         // a huge height is only ever partly sent
         if (eff_h > 8) frame_len = eff_w * eff_c * $urandom_range(3, 10);
         repeat ($urandom_range(1, 3)) begin
            send_frame(frame_len, $urandom_range(2), $urandom_range(3) == 0);
            random_samples += frame_len;
            case ($urandom_range(3))
               1: drain(lag + $urandom_range(0, 3));
               2: drain($urandom_range(1, lag));
               default: ;
            endcase
         end
         if ($urandom_range(3) == 0) begin
            partial = $urandom_range(1, frame_len - 1);
            send_frame(partial, $urandom_range(2), 1'b1);
            random_samples += partial;
         end
      end

      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited != 0) @(negedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d words over %0d register settings, from 3x3 mono frames up to",
               words_sent, settings_used);
      $display("the widest and tallest settings; %0d results checked, %0d frame ends seen",
               results_checked, frames_closed);
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/isfp_pkg.sv
src/isfp_linebuf.sv
src/isfp_ctrl.sv
src/isfp_datapath.sv
src/image_sharpen_five_point.sv
src/isfp_checker.sv
tb/sharpen_checker.sv
tb/tb_top.sv
